[src/html_minify_stream_core_macros.svh]
`ifndef HTML_MINIFY_STREAM_CORE_MACROS_SVH
`define HTML_MINIFY_STREAM_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define HMIN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define HMIN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/hmin_pkg.sv]
package hmin_pkg;

	localparam int BLANK_HOLD_DEPTH  = 32;
	localparam int PREFIX_HOLD_DEPTH = 16;
	localparam int LEVEL_BITS        = 8;
	localparam int QUEUE_DEPTH       = 4;

	typedef enum logic [2:0] {
		M_TEXT, M_LTHOLD, M_COMMENT, M_TSTART, M_TPRE, M_TNAME, M_TREST, M_DECIDE
	} mode_t;

	typedef enum logic [1:0] {OP_BYTE, OP_MARK, OP_END} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data;
	} op_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [63:0] KW_WORD [4] = '{"pre", "textarea", "script", "style"};
	localparam logic [3:0]  KW_LEN  [4] = '{4'd3, 4'd8, 4'd6, 4'd5};

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_namech(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
			(b >= "0" && b <= "9") || (b == CH_DASH) || (b == CH_COLON);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
		logic [3:0] pos;
		pos = KW_LEN[k] - 4'd1 - i;
		return KW_WORD[k][{pos[2:0], 3'b000} +: 8];
	endfunction

	function automatic logic [3:0] name_step(input logic [3:0] cand, input logic [3:0] nl,
		input logic [7:0] b);
		logic [3:0] c;
		c = cand;
		for (int k = 0; k < 4; k++) begin
			if (c[k] && !(nl < KW_LEN[k] && to_lower(b) == kw_char(2'(k), nl)))
				c[k] = 1'b0;
		end
		return c;
	endfunction

	function automatic logic [3:0] name_finish(input logic [3:0] cand, input logic [3:0] nl);
		logic [3:0] c;
		c = cand;
		for (int k = 0; k < 4; k++) begin
			if (KW_LEN[k] != nl)
				c[k] = 1'b0;
		end
		return c;
	endfunction

endpackage

[src/hmin_ram.sv]
module hmin_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/hmin_fifo.sv]
module hmin_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hmin_pkg::op_t  push_op,
	output logic           full,
	output logic           valid,
	output hmin_pkg::op_t  head_op,
	input  logic           pop
);

	localparam int PW = $clog2(hmin_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(hmin_pkg::QUEUE_DEPTH + 1);

	hmin_pkg::op_t slot_q [hmin_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = cnt_q == CW'(hmin_pkg::QUEUE_DEPTH);
	assign valid   = cnt_q != '0;
	assign head_op = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + PW'(1);
			if (do_pop)
				rd_q <= rd_q + PW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

[src/hmin_front.sv]
module hmin_front #(
	parameter int PREFIX_HOLD_DEPTH = hmin_pkg::PREFIX_HOLD_DEPTH,
	parameter int LEVEL_BITS        = hmin_pkg::LEVEL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_data,
	input  logic          in_last,
	output logic          push,
	output hmin_pkg::op_t push_op,
	input  logic          q_full
);

	localparam int PC_W = $clog2(PREFIX_HOLD_DEPTH + 1);
	localparam int IX_W = $clog2(PREFIX_HOLD_DEPTH);
	localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = '1;

	typedef enum logic [2:0] {P_IDLE, P_FEED, P_REPLAY, P_VERB, P_FIN, P_END} phase_t;

	typedef struct packed {
		hmin_pkg::mode_t mode;
		logic            closing;
		logic [3:0]      nl;
		logic [3:0]      cand;
		logic            qopen;
		logic            qdbl;
		logic            sw;
	} tag_ctx_t;

	localparam tag_ctx_t CTX_RST = '{mode: hmin_pkg::M_TEXT, closing: 1'b0, nl: 4'd0,
		cand: 4'hF, qopen: 1'b0, qdbl: 1'b0, sw: 1'b0};

	phase_t                phase_q, n_phase;
	tag_ctx_t              ctx_q, n_ctx, tc;
	logic [LEVEL_BITS-1:0] level_q, n_level;
	logic                  pend_q, n_pend;
	logic [1:0]            cprog_q, n_cprog;
	logic [PC_W-1:0]       pc_q, n_pc, idx_q, n_idx;
	logic                  follow_q, n_follow;
	logic [7:0]            prev_q, n_prev;
	logic                  any_q, n_any;
	logic [7:0]            cur_q;
	logic                  last_q;
	logic [7:0]            hold_q [PREFIX_HOLD_DEPTH];

	logic       hold_we;
	logic [7:0] tb, t_eb, emit_b;
	logic       took, t_dbl, t_em, t_inc, t_dec;
	logic       emit_v, mark_v, end_v, go, nm;
	logic [3:0] cand_f, cand_s;
	phase_t     done_phase;

	assign in_ready   = (phase_q == P_IDLE) && !q_full;
	assign go         = !q_full;
	assign done_phase = last_q ? P_FIN : P_IDLE;

	always_comb begin
		tb    = (phase_q == P_REPLAY) ? hold_q[idx_q[IX_W-1:0]] : cur_q;
		tc    = ctx_q;
		took  = 1'b0;
		t_em  = 1'b0;
		t_eb  = tb;
		t_inc = 1'b0;
		t_dec = 1'b0;
		t_dbl = tb == hmin_pkg::CH_DQ;
		if (tc.mode == hmin_pkg::M_TSTART) begin
			tc.mode = hmin_pkg::M_TPRE;
			if (tb == hmin_pkg::CH_SLASH) begin
				tc.closing = 1'b1;
				took       = 1'b1;
			end
		end
		if (!took && tc.mode == hmin_pkg::M_TPRE) begin
			if (hmin_pkg::is_namech(tb)) begin
				tc.cand = hmin_pkg::name_step(tc.cand, tc.nl, tb);
				tc.nl   = tc.nl + 4'(tc.nl != 4'd15);
				tc.mode = hmin_pkg::M_TNAME;
			end else if (!hmin_pkg::is_blank(tb)) begin
				tc.cand = hmin_pkg::name_finish(tc.cand, tc.nl);
				tc.mode = hmin_pkg::M_TREST;
			end
		end else if (!took && tc.mode == hmin_pkg::M_TNAME) begin
			if (hmin_pkg::is_namech(tb)) begin
				tc.cand = hmin_pkg::name_step(tc.cand, tc.nl, tb);
				tc.nl   = tc.nl + 4'(tc.nl != 4'd15);
			end else begin
				tc.cand = hmin_pkg::name_finish(tc.cand, tc.nl);
				tc.mode = hmin_pkg::M_TREST;
			end
		end
		if (tb == hmin_pkg::CH_SQ || tb == hmin_pkg::CH_DQ) begin
			t_em = 1'b1;
			if (tc.qopen && tc.qdbl == t_dbl) begin
				tc.qopen = 1'b0;
			end else if (!tc.qopen) begin
				tc.qopen = 1'b1;
				tc.qdbl  = t_dbl;
			end
			tc.sw = 1'b0;
		end else if (!tc.qopen && hmin_pkg::is_blank(tb)) begin
			if (!tc.sw) begin
				tc.sw = 1'b1;
				t_em  = 1'b1;
				t_eb  = hmin_pkg::CH_SP;
			end
		end else if (!tc.qopen && tb == hmin_pkg::CH_GT) begin
			t_em = 1'b1;
			if (tc.cand != 4'd0) begin
				if (tc.closing)
					t_dec = 1'b1;
				else
					t_inc = 1'b1;
			end
			tc.mode = hmin_pkg::M_TEXT;
		end else begin
			t_em  = 1'b1;
			tc.sw = 1'b0;
		end
	end

	always_comb begin
		n_phase  = phase_q;
		n_ctx    = ctx_q;
		n_level  = level_q;
		n_pend   = pend_q;
		n_cprog  = cprog_q;
		n_pc     = pc_q;
		n_idx    = idx_q;
		n_follow = follow_q;
		hold_we  = 1'b0;
		emit_v   = 1'b0;
		emit_b   = cur_q;
		mark_v   = 1'b0;
		end_v    = 1'b0;
		nm       = hmin_pkg::is_namech(cur_q);
		cand_f   = hmin_pkg::name_finish(ctx_q.cand, ctx_q.nl);
		cand_s   = hmin_pkg::name_step(ctx_q.cand, ctx_q.nl, cur_q);
		case (phase_q)
			P_IDLE: begin
				if (in_valid && !q_full) begin
					mark_v  = in_last;
					n_phase = P_FEED;
				end
			end
			P_FEED: begin
				if (go) begin
					case (ctx_q.mode)
						hmin_pkg::M_TEXT: begin
							n_phase = done_phase;
							if (cur_q == hmin_pkg::CH_LT) begin
								n_pend = 1'b0;
								n_ctx  = CTX_RST;
								n_pc   = '0;
								if (level_q == '0) begin
									n_ctx.mode = hmin_pkg::M_LTHOLD;
								end else begin
									emit_v     = 1'b1;
									emit_b     = hmin_pkg::CH_LT;
									n_ctx.mode = hmin_pkg::M_DECIDE;
								end
							end else if (level_q != '0) begin
								emit_v = 1'b1;
							end else if (hmin_pkg::is_blank(cur_q)) begin
								n_pend = any_q && prev_q != 8'd0 && prev_q != hmin_pkg::CH_GT;
							end else if (pend_q && cur_q != 8'd0) begin
								emit_v  = 1'b1;
								emit_b  = hmin_pkg::CH_SP;
								n_pend  = 1'b0;
								n_phase = P_FEED;
							end else begin
								n_pend = 1'b0;
								emit_v = 1'b1;
							end
						end
						hmin_pkg::M_LTHOLD: begin
							hold_we = 1'b1;
							n_pc    = pc_q + PC_W'(1);
							n_phase = done_phase;
							if (cur_q != ((pc_q == '0) ? hmin_pkg::CH_BANG : hmin_pkg::CH_DASH)) begin
								emit_v     = 1'b1;
								emit_b     = hmin_pkg::CH_LT;
								n_ctx.mode = hmin_pkg::M_TSTART;
								n_ctx.nl   = 4'd0;
								n_ctx.cand = 4'hF;
								n_idx      = '0;
								n_follow   = 1'b0;
								n_phase    = P_REPLAY;
							end else if (pc_q >= PC_W'(2)) begin
								n_pc       = '0;
								n_cprog    = 2'd0;
								n_ctx.mode = hmin_pkg::M_COMMENT;
							end
						end
						hmin_pkg::M_COMMENT: begin
							n_phase = done_phase;
							if (cur_q == hmin_pkg::CH_DASH) begin
								if (cprog_q != 2'd2)
									n_cprog = cprog_q + 2'd1;
							end else if (cur_q == hmin_pkg::CH_GT && cprog_q == 2'd2) begin
								n_cprog    = 2'd0;
								n_ctx.mode = hmin_pkg::M_TEXT;
							end else begin
								n_cprog = 2'd0;
							end
						end
						hmin_pkg::M_DECIDE: begin
							if (pc_q == '0 && cur_q == hmin_pkg::CH_SLASH) begin
								n_ctx.mode = hmin_pkg::M_TSTART;
							end else if (nm || (hmin_pkg::is_blank(cur_q) && ctx_q.nl == 4'd0)) begin
								if (pc_q >= PC_W'(PREFIX_HOLD_DEPTH)) begin
									n_idx    = '0;
									n_follow = 1'b1;
									n_phase  = P_VERB;
								end else begin
									hold_we = 1'b1;
									n_pc    = pc_q + PC_W'(1);
									n_phase = done_phase;
									if (nm) begin
										n_ctx.cand = cand_s;
										n_ctx.nl   = ctx_q.nl + 4'(ctx_q.nl != 4'd15);
										if (cand_s == 4'd0) begin
											n_idx    = '0;
											n_follow = 1'b0;
											n_phase  = P_VERB;
										end
									end
								end
							end else begin
								n_idx    = '0;
								n_follow = 1'b1;
								if (cand_f != 4'd0) begin
									n_ctx.mode = hmin_pkg::M_TSTART;
									n_ctx.nl   = 4'd0;
									n_ctx.cand = 4'hF;
									n_phase    = P_REPLAY;
								end else begin
									n_ctx.cand = cand_f;
									n_phase    = P_VERB;
								end
							end
						end
						default: begin
							n_ctx   = tc;
							emit_v  = t_em;
							emit_b  = t_eb;
							n_phase = done_phase;
							if (t_dec && level_q != '0)
								n_level = level_q - LEVEL_BITS'(1);
							if (t_inc && level_q != LEVEL_TOP)
								n_level = level_q + LEVEL_BITS'(1);
						end
					endcase
				end
			end
			P_REPLAY: begin
				if (go) begin
					if (idx_q < pc_q) begin
						n_ctx  = tc;
						emit_v = t_em;
						emit_b = t_eb;
						n_idx  = idx_q + PC_W'(1);
						if (t_dec && level_q != '0)
							n_level = level_q - LEVEL_BITS'(1);
						if (t_inc && level_q != LEVEL_TOP)
							n_level = level_q + LEVEL_BITS'(1);
					end else begin
						n_pc    = '0;
						n_idx   = '0;
						n_phase = follow_q ? P_FEED : done_phase;
					end
				end
			end
			P_VERB: begin
				if (go) begin
					if (idx_q < pc_q) begin
						emit_v = 1'b1;
						emit_b = hold_q[idx_q[IX_W-1:0]];
						n_idx  = idx_q + PC_W'(1);
					end else begin
						n_pc       = '0;
						n_idx      = '0;
						n_ctx.mode = hmin_pkg::M_TEXT;
						n_phase    = follow_q ? P_FEED : done_phase;
					end
				end
			end
			P_FIN: begin
				if (go) begin
					n_idx    = '0;
					n_follow = 1'b0;
					if (ctx_q.mode == hmin_pkg::M_LTHOLD) begin
						emit_v     = 1'b1;
						emit_b     = hmin_pkg::CH_LT;
						n_ctx.mode = hmin_pkg::M_TSTART;
						n_ctx.nl   = 4'd0;
						n_ctx.cand = 4'hF;
						n_phase    = P_REPLAY;
					end else if (ctx_q.mode == hmin_pkg::M_DECIDE) begin
						if (cand_f != 4'd0) begin
							n_ctx.mode = hmin_pkg::M_TSTART;
							n_ctx.nl   = 4'd0;
							n_ctx.cand = 4'hF;
							n_phase    = P_REPLAY;
						end else begin
							n_ctx.cand = cand_f;
							n_phase    = P_VERB;
						end
					end else begin
						n_phase = P_END;
					end
				end
			end
			P_END: begin
				if (go) begin
					end_v    = 1'b1;
					n_ctx    = CTX_RST;
					n_level  = '0;
					n_pend   = 1'b0;
					n_cprog  = 2'd0;
					n_pc     = '0;
					n_idx    = '0;
					n_follow = 1'b0;
					n_phase  = P_IDLE;
				end
			end
			default: n_phase = P_IDLE;
		endcase
		n_prev = emit_v ? emit_b : prev_q;
		n_any  = any_q || emit_v;
		if (end_v) begin
			n_prev = 8'd0;
			n_any  = 1'b0;
		end
	end

	always_comb begin
		push         = emit_v || mark_v || end_v;
		push_op.data = emit_b;
		if (end_v) begin
			push_op.kind = hmin_pkg::OP_END;
			push_op.data = 8'd0;
		end else if (mark_v) begin
			push_op.kind = hmin_pkg::OP_MARK;
			push_op.data = 8'd0;
		end else begin
			push_op.kind = hmin_pkg::OP_BYTE;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_we)
			hold_q[pc_q[IX_W-1:0]] <= cur_q;
		if (phase_q == P_IDLE && in_valid && !q_full) begin
			cur_q  <= in_data;
			last_q <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_IDLE;
			ctx_q    <= CTX_RST;
			level_q  <= '0;
			pend_q   <= 1'b0;
			cprog_q  <= 2'd0;
			pc_q     <= '0;
			idx_q    <= '0;
			follow_q <= 1'b0;
			prev_q   <= 8'd0;
			any_q    <= 1'b0;
		end else begin
			phase_q  <= n_phase;
			ctx_q    <= n_ctx;
			level_q  <= n_level;
			pend_q   <= n_pend;
			cprog_q  <= n_cprog;
			pc_q     <= n_pc;
			idx_q    <= n_idx;
			follow_q <= n_follow;
			prev_q   <= n_prev;
			any_q    <= n_any;
		end
	end

endmodule

[src/hmin_back.sv]
module hmin_back #(
	parameter int BLANK_HOLD_DEPTH = hmin_pkg::BLANK_HOLD_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  hmin_pkg::op_t q_op,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_flag,
	output logic          out_end
);

	localparam int AW = $clog2(BLANK_HOLD_DEPTH);
	localparam int CW = $clog2(BLANK_HOLD_DEPTH + 1);

	typedef enum logic [1:0] {B_IDLE, B_RD, B_OUT} bstate_t;

	bstate_t       st_q, n_st;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;
	logic          one_q, n_one;
	logic          pend_v_q;
	logic [7:0]    pend_q;
	logic [7:0]    rdata, give_b;
	logic          out_free, can_give, we, give_v, fin, mflush, rel;

	assign out_free = !out_valid || out_ready;
	assign can_give = !pend_v_q || out_free;

	hmin_ram #(.WIDTH(8), .DEPTH(BLANK_HOLD_DEPTH)) u_blank_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (q_op.data),
		.raddr (head_q),
		.rdata (rdata)
	);

	always_comb begin
		n_st   = st_q;
		n_one  = one_q;
		q_pop  = 1'b0;
		we     = 1'b0;
		give_v = 1'b0;
		give_b = rdata;
		fin    = 1'b0;
		mflush = 1'b0;
		rel    = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					case (q_op.kind)
						hmin_pkg::OP_END: begin
							if (out_free) begin
								fin   = 1'b1;
								q_pop = 1'b1;
							end
						end
						hmin_pkg::OP_MARK: begin
							if (!pend_v_q) begin
								q_pop = 1'b1;
							end else if (out_free) begin
								mflush = 1'b1;
								q_pop  = 1'b1;
							end
						end
						hmin_pkg::OP_BYTE: begin
							if (hmin_pkg::is_blank(q_op.data)) begin
								if (cnt_q == CW'(BLANK_HOLD_DEPTH)) begin
									n_one = 1'b1;
									n_st  = B_RD;
								end else begin
									we    = 1'b1;
									q_pop = 1'b1;
								end
							end else if (cnt_q != '0) begin
								n_one = 1'b0;
								n_st  = B_RD;
							end else if (can_give) begin
								give_v = 1'b1;
								give_b = q_op.data;
								q_pop  = 1'b1;
							end
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			B_RD: n_st = B_OUT;
			B_OUT: begin
				if (can_give) begin
					give_v = 1'b1;
					rel    = 1'b1;
					n_st   = (one_q || cnt_q == CW'(1)) ? B_IDLE : B_RD;
				end
			end
			default: n_st = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			one_q     <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			pend_v_q  <= 1'b0;
			pend_q    <= 8'd0;
			out_valid <= 1'b0;
			out_byte  <= 8'd0;
			out_flag  <= 1'b0;
			out_end   <= 1'b0;
		end else begin
			st_q  <= n_st;
			one_q <= n_one;
			if ((give_v && pend_v_q) || mflush) begin
				out_valid <= 1'b1;
				out_byte  <= pend_q;
				out_flag  <= 1'b1;
				out_end   <= 1'b0;
			end else if (fin) begin
				out_valid <= 1'b1;
				out_byte  <= pend_v_q ? pend_q : 8'd0;
				out_flag  <= pend_v_q;
				out_end   <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (give_v) begin
				pend_q   <= give_b;
				pend_v_q <= 1'b1;
			end
			if (mflush)
				pend_v_q <= 1'b0;
			if (we) begin
				tail_q <= (tail_q == AW'(BLANK_HOLD_DEPTH - 1)) ? '0 : tail_q + AW'(1);
				cnt_q  <= cnt_q + CW'(1);
			end
			if (rel) begin
				head_q <= (head_q == AW'(BLANK_HOLD_DEPTH - 1)) ? '0 : head_q + AW'(1);
				cnt_q  <= cnt_q - CW'(1);
			end
			if (fin) begin
				pend_v_q <= 1'b0;
				head_q   <= '0;
				tail_q   <= '0;
				cnt_q    <= '0;
			end
		end
	end

endmodule

[src/html_minify_stream_core.sv]
// channel  | handshake               | tdata                | tuser          | tlast
// s_axis   | s_axis_tvalid/_tready   | [7:0] data_byte      | -              | last
// m_axis   | m_axis_tvalid/_tready   | [7:0] out_byte       | [0] byte_valid | end_of_output
//
// An input item is taken in the idle phase and parsed in the feed phase, which repeats
// for an extra emitted byte; held tag prefixes replay at one byte a cycle while the op
// queue has room, then take a closing step. The last item of a document adds a flush
// and an end-item phase. Held blanks leave via a read and an output state (registered RAM).
// Reset clears all control state; the blank RAM needs no clearing pass.
// Either side may stall; the four-entry op queue and the output register absorb it.
module html_minify_stream_core #(
	parameter int BLANK_HOLD_DEPTH  = hmin_pkg::BLANK_HOLD_DEPTH,
	parameter int PREFIX_HOLD_DEPTH = hmin_pkg::PREFIX_HOLD_DEPTH,
	parameter int LEVEL_BITS        = hmin_pkg::LEVEL_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [0:0] m_axis_tuser,   // [0] byte_valid
	output logic       m_axis_tlast
);

	logic          push, q_full, q_valid, q_pop;
	hmin_pkg::op_t push_op, head_op;

	hmin_front #(
		.PREFIX_HOLD_DEPTH (PREFIX_HOLD_DEPTH),
		.LEVEL_BITS        (LEVEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.push     (push),
		.push_op  (push_op),
		.q_full   (q_full)
	);

	hmin_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.valid   (q_valid),
		.head_op (head_op),
		.pop     (q_pop)
	);

	hmin_back #(.BLANK_HOLD_DEPTH(BLANK_HOLD_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (head_op),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_flag  (m_axis_tuser[0]),
		.out_end   (m_axis_tlast)
	);

endmodule

[src/hmin_chk.sv]
`include "html_minify_stream_core_macros.svh"

module hmin_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [0:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	logic in_take;
	assign in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

	`HMIN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")
	`HMIN_ASSERT_NOW(a_empty_is_end, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast, "empty item without end mark")
	`HMIN_ASSERT_NOW(a_empty_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0, "empty item with nonzero byte")
	`HMIN_ASSERT_NEXT(a_one_at_a_time, in_take && !s_axis_tlast, !s_axis_tready, "second item taken before first parsed")

endmodule

bind html_minify_stream_core hmin_chk u_chk (.*);

[dv/tb_html_minify_stream_core.sv]
module tb_html_minify_stream_core;
	import hmin_pkg::*;

	typedef struct {
		logic [7:0] data;
		bit         valid;
		bit         fin;
	} out_item_t;

	class minify_scoreboard;
		mode_t       mode;
		int unsigned level;
		bit          closing;
		bit [3:0]    nlen;
		bit [3:0]    cand;
		bit          q_open, q_dbl, sp_wr, txt_sp, any_out;
		bit [1:0]    dash_run;
		logic [7:0]  pfx [PREFIX_HOLD_DEPTH];
		int          pfx_n;
		logic [7:0]  blanks [$];
		logic [7:0]  prev;
		out_item_t   step_q [$];
		out_item_t   expected [$];
		int          mismatches;
		string       kw [4] = '{"pre", "textarea", "script", "style"};

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			mode = M_TEXT;
			level = 0;
			closing = 0;
			nlen = 0;
			cand = 4'hF;
			q_open = 0;
			q_dbl = 0;
			sp_wr = 0;
			txt_sp = 0;
			any_out = 0;
			dash_run = 0;
			pfx_n = 0;
			blanks.delete();
			prev = 0;
		endfunction

		function bit blank_ch(logic [7:0] b);
			return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
		endfunction

		function bit name_ch(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
				(b >= "0" && b <= "9") || b == CH_DASH || b == CH_COLON;
		endfunction

		function logic [7:0] lower_ch(logic [7:0] b);
			return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		endfunction

		function void put(logic [7:0] b);
			out_item_t r;
			if (step_q.size() < 49) begin
				r.data = b;
				r.valid = 1;
				r.fin = 0;
				step_q.push_back(r);
			end
		endfunction

		function void send_out(logic [7:0] b);
			prev = b;
			any_out = 1;
			if (blank_ch(b)) begin
				if (blanks.size() >= BLANK_HOLD_DEPTH)
					put(blanks.pop_front());
				blanks.push_back(b);
			end else begin
				while (blanks.size() > 0)
					put(blanks.pop_front());
				put(b);
			end
		endfunction

		function void name_add(logic [7:0] b);
			for (int k = 0; k < 4; k++) begin
				if (cand[k]) begin
					if (!(nlen < kw[k].len() && lower_ch(b) == kw[k][nlen]))
						cand[k] = 0;
				end
			end
			if (nlen < 15)
				nlen++;
		endfunction

		function void name_done();
			for (int k = 0; k < 4; k++)
				if (kw[k].len() != nlen)
					cand[k] = 0;
		endfunction

		function void tag_in(logic [7:0] b);
			bit took;
			took = 0;
			if (mode == M_TSTART) begin
				mode = M_TPRE;
				if (b == CH_SLASH) begin
					closing = 1;
					took = 1;
				end
			end
			if (!took && mode == M_TPRE) begin
				if (name_ch(b)) begin
					name_add(b);
					mode = M_TNAME;
				end else if (!blank_ch(b)) begin
					name_done();
					mode = M_TREST;
				end
			end else if (!took && mode == M_TNAME) begin
				if (name_ch(b)) begin
					name_add(b);
				end else begin
					name_done();
					mode = M_TREST;
				end
			end
			if (b == CH_SQ || b == CH_DQ) begin
				send_out(b);
				if (q_open && q_dbl == (b == CH_DQ)) begin
					q_open = 0;
				end else if (!q_open) begin
					q_open = 1;
					q_dbl = (b == CH_DQ);
				end
				sp_wr = 0;
			end else if (!q_open && blank_ch(b)) begin
				if (!sp_wr) begin
					sp_wr = 1;
					send_out(CH_SP);
				end
			end else if (!q_open && b == CH_GT) begin
				send_out(CH_GT);
				if (cand != 0) begin
					if (closing) begin
						if (level > 0)
							level--;
					end else if (level < (1 << LEVEL_BITS) - 1) begin
						level++;
					end
				end
				mode = M_TEXT;
			end else begin
				send_out(b);
				sp_wr = 0;
			end
		endfunction

		function void text_in(logic [7:0] b);
			if (b == CH_LT) begin
				txt_sp = 0;
				closing = 0;
				q_open = 0;
				q_dbl = 0;
				sp_wr = 0;
				nlen = 0;
				cand = 4'hF;
				pfx_n = 0;
				if (level == 0) begin
					mode = M_LTHOLD;
				end else begin
					send_out(CH_LT);
					mode = M_DECIDE;
				end
			end else if (level > 0) begin
				send_out(b);
			end else if (blank_ch(b)) begin
				txt_sp = any_out && prev != 0 && prev != CH_GT;
			end else begin
				if (txt_sp && b != 0)
					send_out(CH_SP);
				txt_sp = 0;
				send_out(b);
			end
		endfunction

		function void replay_tag();
			int n;
			n = pfx_n;
			pfx_n = 0;
			mode = M_TSTART;
			nlen = 0;
			cand = 4'hF;
			for (int i = 0; i < n; i++)
				tag_in(pfx[i]);
		endfunction

		function void copy_held();
			for (int i = 0; i < pfx_n; i++)
				send_out(pfx[i]);
			pfx_n = 0;
			mode = M_TEXT;
		endfunction

		function void byte_in(logic [7:0] b);
			logic [7:0] bang [3] = '{CH_BANG, CH_DASH, CH_DASH};
			bit hit;
			case (mode)
				M_TEXT: text_in(b);
				M_LTHOLD: begin
					hit = (b == bang[pfx_n]);
					pfx[pfx_n] = b;
					pfx_n++;
					if (!hit) begin
						send_out(CH_LT);
						replay_tag();
					end else if (pfx_n >= 3) begin
						pfx_n = 0;
						dash_run = 0;
						mode = M_COMMENT;
					end
				end
				M_COMMENT: begin
					if (b == CH_DASH) begin
						if (dash_run < 2)
							dash_run++;
					end else if (b == CH_GT && dash_run == 2) begin
						dash_run = 0;
						mode = M_TEXT;
					end else begin
						dash_run = 0;
					end
				end
				M_DECIDE: begin
					if (pfx_n == 0 && b == CH_SLASH) begin
						mode = M_TSTART;
						tag_in(b);
					end else if (name_ch(b) || (blank_ch(b) && nlen == 0)) begin
						if (pfx_n >= PREFIX_HOLD_DEPTH) begin
							copy_held();
							text_in(b);
						end else begin
							pfx[pfx_n] = b;
							pfx_n++;
							if (name_ch(b)) begin
								name_add(b);
								if (cand == 0)
									copy_held();
							end
						end
					end else begin
						name_done();
						if (cand != 0) begin
							replay_tag();
							tag_in(b);
						end else begin
							copy_held();
							text_in(b);
						end
					end
				end
				default: tag_in(b);
			endcase
		endfunction

		function void note_input(logic [7:0] b, bit fin);
			out_item_t r;
			step_q.delete();
			byte_in(b);
			if (fin) begin
				if (mode == M_LTHOLD) begin
					send_out(CH_LT);
					replay_tag();
				end else if (mode == M_DECIDE) begin
					name_done();
					if (cand != 0)
						replay_tag();
					else
						copy_held();
				end
				if (step_q.size() == 0) begin
					r.data = 0;
					r.valid = 0;
					r.fin = 1;
					step_q.push_back(r);
				end else begin
					step_q[step_q.size() - 1].fin = 1;
				end
				clear();
			end
			foreach (step_q[i])
				expected.push_back(step_q[i]);
		endfunction

		function void check(logic [7:0] data, bit valid, bit fin);
			out_item_t e;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: byte %h valid %b last %b", data, valid, fin);
				return;
			end
			e = expected.pop_front();
			if (e.data !== data || e.valid !== valid || e.fin !== fin) begin
				mismatches++;
				if (mismatches <= 10)
					$display("item mismatch: expected byte %h valid %b last %b, got %h %b %b",
						e.data, e.valid, e.fin, data, valid, fin);
			end
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       s_axis_tvalid = 0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic       s_axis_tlast = 0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 0;
	logic [7:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic       m_axis_tlast;

	minify_scoreboard sb = new();
	int snd_idle = 0;
	int rcv_stall = 0;
	int hold_rx = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	logic [7:0] doc [$];

	html_minify_stream_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_rx > 0) begin
				hold_rx--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input bit fin);
		if ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 0;
			do @(negedge clk); while ($urandom_range(99) < snd_idle);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(b, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_doc();
		foreach (doc[i])
			push_byte(doc[i], i == doc.size() - 1);
		doc.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			doc.push_back(s[i]);
	endtask

	task automatic add_blanks(input int n);
		logic [7:0] pick [6] = '{8'h20, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
		repeat (n)
			doc.push_back(pick[$urandom_range(5)]);
	endtask

	task automatic add_name(input string s);
		for (int i = 0; i < s.len(); i++)
			doc.push_back(($urandom_range(1) && s[i] >= "a" && s[i] <= "z") ?
				s[i] - 8'd32 : s[i]);
	endtask

	task automatic add_word();
		repeat ($urandom_range(1, 6))
			doc.push_back($urandom_range(1) ? $urandom_range("a", "z") :
				$urandom_range("A", "Z"));
	endtask

	task automatic build_doc();
		string kws [4] = '{"pre", "textarea", "script", "style"};
		repeat ($urandom_range(3, 10)) begin
			case ($urandom_range(11))
				0: add_word();
				1: add_blanks($urandom_range(1, 4));
				2: begin
					add_str("<");
					add_name(kws[$urandom_range(3)]);
					add_str(">");
				end
				3: begin
					add_str("</");
					add_name(kws[$urandom_range(3)]);
					add_str(">");
				end
				4: begin
					add_str("<div");
					add_blanks($urandom_range(1, 3));
					add_str($urandom_range(1) ? "a=\"x  '>y\"" : "b='q \"z'");
					add_blanks($urandom_range(0, 2));
					add_str(">");
				end
				5: begin
					add_str("<!--");
					add_word();
					add_str($urandom_range(1) ? "-- -" : "->");
					add_str("-->");
				end
				6: doc.push_back($urandom_range(255));
				7: begin
					add_str("<");
					doc.push_back($urandom_range(255));
				end
				8: add_str($urandom_range(1) ? "\"a  b\"" : "'c'");
				9: begin
					add_str("</");
					add_word();
					add_str(">");
				end
				10: add_blanks($urandom_range(30, 40));
				default: add_str($urandom_range(1) ? "<!" : "<!-");
			endcase
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.expected.size() > 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	initial begin
		int idle_set [4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{6, 6}};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		add_str("  Hello \t World  ");
		send_doc();
		add_str("<A HREF='x  y'>  a <!-- c --> b  </a>");
		send_doc();
		add_str("</pre>x<PRE> a  b <i>\n</Pre>");
		send_doc();
		add_str("<pre><");
		add_blanks(20);
		add_str(">z");
		send_doc();
		add_str("<style>");
		add_blanks(40);
		add_str("x</style>");
		send_doc();
		add_str("a  ");
		doc.push_back(8'h00);
		add_str("  b");
		doc.push_back(8'hFF);
		doc.push_back(8'h80);
		send_doc();
		add_str("x<!-- open");
		send_doc();
		add_str("<textarea><scr");
		send_doc();
		add_str("<");
		send_doc();
		add_str(" ");
		send_doc();
		drain();

		for (int p = 0; p < 4; p++) begin
			snd_idle = idle_set[p][0];
			rcv_stall = idle_set[p][1];
			if (p == 1)
				hold_rx = 300;
			while (items_sent < 190 + (p + 1) * 65) begin
				build_doc();
				send_doc();
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/hmin_pkg.sv
src/hmin_ram.sv
src/hmin_fifo.sv
src/hmin_front.sv
src/hmin_back.sv
src/html_minify_stream_core.sv
src/hmin_chk.sv
dv/tb_html_minify_stream_core.sv
